[hdl/assert_macros.svh]
// assertion macros for the hit-test block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clk, off while reset is held
`define PIPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge of clk, reset included
`define PIPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/pipt_pkg.sv]
// shared types and constants of the polygon hit-test block
`default_nettype none

package pipt_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int FAR_BITS   = COORD_BITS + 4;
  localparam int PROD_BITS  = FAR_BITS + DIFF_BITS;

  typedef enum logic [0:0] {
    ACT_APPEND = 1'b0,
    ACT_QUERY  = 1'b1
  } action_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   coord_hi_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [FAR_BITS-1:0]   far_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  typedef struct packed {
    action_t action;
    coord_t  x_coord;
    coord_t  y_coord;
    logic    first_vertex;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic vertices_dropped;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/pipt_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none

module pipt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/point_in_polygon_test_top.sv]
// top level of the polygon hit-test block
`default_nettype none
`include "assert_macros.svh"

// Polygon hit test. A transaction is taken when start is high and busy is low.
// An append stores one vertex in the vertex memory (one past capacity is
// dropped and flagged instead) and leaves busy low, so appends can follow each
// other every cycle; it gives no result. A query gives exactly one result,
// shown on out_item for one cycle with out_valid high; the receiver cannot
// hold it off. A query that is rejected early (open path, empty polygon, point
// outside the bounding box) answers in the cycle after it is taken. Otherwise
// the query walks the stored vertices through the single read port of the
// vertex memory, one vertex a cycle while no crossing is being checked: each
// edge that crosses the ray holds the walk for S_MUL0, S_MUL1, S_MUL2 and S_CMP
// on the shared multiplier. There is no clearing pass after reset.
module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire pipt_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output pipt_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int KW = AW + 1;
  localparam int C  = pipt_pkg::COORD_BITS;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

  typedef enum logic [2:0] {
    S_IDLE, S_SEEK, S_WALK, S_MUL0, S_MUL1, S_MUL2, S_CMP
  } state_t;

  state_t              state_r, state_nxt;
  logic                open_path_r, open_path_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                overflow_r, overflow_nxt;
  pipt_pkg::coord_t    box_xl_r, box_xl_nxt, box_yl_r, box_yl_nxt;
  pipt_pkg::coord_hi_t box_xh_r, box_xh_nxt, box_yh_r, box_yh_nxt;
  pipt_pkg::coord_t    px_r, px_nxt, py_r, py_nxt;
  pipt_pkg::far_t      far_r, far_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic                anchor_neg_r, anchor_neg_nxt;
  logic                run_empty_r, run_empty_nxt;
  pipt_pkg::coord_t    run_x_r, run_x_nxt;
  pipt_pkg::coord_t    prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic                parity_r, parity_nxt;
  logic                last_r, last_nxt;
  pipt_pkg::diff_t     dx_r, dx_nxt, dy_r, dy_nxt, gy_r, gy_nxt;
  pipt_pkg::far_t      ex_r, ex_nxt, fx_r, fx_nxt;
  pipt_pkg::prod_t     p_r, p_nxt, q_r, q_nxt, r_r, r_nxt;
  logic                out_valid_r, out_valid_nxt;
  pipt_pkg::out_item_t out_item_r, out_item_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [2*C-1:0]         ram_rdata;
  pipt_pkg::coord_t       rd_x, rd_y;

  logic                   accept;
  logic [KW-1:0]          n_k, kp1;
  logic [CW-1:0]          eff_count;
  pipt_pkg::coord_hi_t    in_xp1, in_yp1;
  logic                   outside;
  logic                   on_line, new_neg, touch;
  pipt_pkg::far_t         mul_a;
  pipt_pkg::diff_t        mul_b;
  pipt_pkg::prod_t        mul_p;
  logic signed [pipt_pkg::PROD_BITS:0] c1, c2;
  logic                   fin, fin_res, par_tmp;

  function automatic logic [AW-1:0] wrap_idx(input logic [KW-1:0] k, input logic [KW-1:0] n);
    logic [KW-1:0] t;
    t = (k >= n) ? k - n : k;
    return t[AW-1:0];
  endfunction

  pipt_ram #(
    .WIDTH (2 * C),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_item.x_coord, in_item.y_coord}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_x   = ram_rdata[2*C-1:C];
  assign rd_y   = ram_rdata[C-1:0];
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign n_k    = KW'(count_r);
  assign kp1    = k_r + 1'b1;

  assign eff_count = in_item.first_vertex ? '0 : count_r;
  assign in_xp1    = (C+1)'(in_item.x_coord) + (C+1)'(1);
  assign in_yp1    = (C+1)'(in_item.y_coord) + (C+1)'(1);
  assign outside   = (in_item.x_coord < box_xl_r) || ((C+1)'(in_item.x_coord) >= box_xh_r) ||
                     (in_item.y_coord < box_yl_r) || ((C+1)'(in_item.y_coord) >= box_yh_r);

  assign on_line = (rd_y == py_r);
  assign new_neg = (rd_y < py_r);
  assign touch   = !run_empty_r &&
                   (((run_x_r <= px_r) && (prev_x_r >= px_r)) ||
                    ((run_x_r >= px_r) && (prev_x_r <= px_r)));

  always_comb begin
    case (state_r)
      S_MUL0: begin
        mul_a = ex_r;
        mul_b = dy_r;
      end
      S_MUL1: begin
        mul_a = fx_r;
        mul_b = dy_r;
      end
      default: begin
        mul_a = pipt_pkg::FAR_BITS'(gy_r);
        mul_b = dx_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign c1    = (pipt_pkg::PROD_BITS+1)'(p_r) - (pipt_pkg::PROD_BITS+1)'(r_r);
  assign c2    = (pipt_pkg::PROD_BITS+1)'(q_r) - (pipt_pkg::PROD_BITS+1)'(r_r);

  always_comb begin
    state_nxt      = state_r;
    open_path_nxt  = cfg_we ? cfg_wdata : open_path_r;
    count_nxt      = count_r;
    overflow_nxt   = overflow_r;
    box_xl_nxt     = box_xl_r;
    box_xh_nxt     = box_xh_r;
    box_yl_nxt     = box_yl_r;
    box_yh_nxt     = box_yh_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    far_nxt        = far_r;
    k_nxt          = k_r;
    anchor_neg_nxt = anchor_neg_r;
    run_empty_nxt  = run_empty_r;
    run_x_nxt      = run_x_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    parity_nxt     = parity_r;
    last_nxt       = last_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    gy_nxt         = gy_r;
    ex_nxt         = ex_r;
    fx_nxt         = fx_r;
    p_nxt          = p_r;
    q_nxt          = q_r;
    r_nxt          = r_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    ram_waddr      = eff_count[AW-1:0];
    ram_raddr      = wrap_idx(k_r, n_k);
    fin            = 1'b0;
    fin_res        = 1'b0;
    par_tmp        = parity_r;

    case (state_r)
      S_IDLE: begin
        if (accept && in_item.action == pipt_pkg::ACT_APPEND) begin
          if (!in_item.first_vertex && count_r == MAX_CNT) begin
            overflow_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            count_nxt = eff_count + 1'b1;
            if (in_item.first_vertex) begin
              overflow_nxt = 1'b0;
            end
            if (eff_count == '0) begin
              box_xl_nxt = in_item.x_coord;
              box_xh_nxt = in_xp1;
              box_yl_nxt = in_item.y_coord;
              box_yh_nxt = in_yp1;
            end else begin
              if (in_item.x_coord < box_xl_r) box_xl_nxt = in_item.x_coord;
              if (in_xp1 > box_xh_r)          box_xh_nxt = in_xp1;
              if (in_item.y_coord < box_yl_r) box_yl_nxt = in_item.y_coord;
              if (in_yp1 > box_yh_r)          box_yh_nxt = in_yp1;
            end
          end
        end else if (accept) begin
          px_nxt = in_item.x_coord;
          py_nxt = in_item.y_coord;
          if (open_path_r || count_r == '0 || outside) begin
            fin     = 1'b1;
            fin_res = 1'b0;
          end else begin
            state_nxt  = S_SEEK;
            k_nxt      = '0;
            ram_raddr  = '0;
            parity_nxt = 1'b0;
            far_nxt    = (pipt_pkg::FAR_BITS'(box_xh_r) <<< 1) - pipt_pkg::FAR_BITS'(box_xl_r);
          end
        end
      end
      S_SEEK: begin
        if (on_line) begin
          if (kp1 == n_k) begin
            fin     = 1'b1;
            fin_res = parity_r;
          end else begin
            k_nxt     = kp1;
            ram_raddr = wrap_idx(kp1, n_k);
          end
        end else begin
          anchor_neg_nxt = new_neg;
          prev_x_nxt     = rd_x;
          prev_y_nxt     = rd_y;
          run_empty_nxt  = 1'b1;
          k_nxt          = kp1;
          ram_raddr      = wrap_idx(kp1, n_k);
          state_nxt      = S_WALK;
        end
      end
      S_WALK: begin
        if (on_line) begin
          if (run_empty_r) begin
            run_x_nxt     = rd_x;
            run_empty_nxt = 1'b0;
          end
          prev_x_nxt = rd_x;
          prev_y_nxt = rd_y;
          k_nxt      = kp1;
          ram_raddr  = wrap_idx(kp1, n_k);
        end else if (touch) begin
          fin     = 1'b1;
          fin_res = 1'b1;
        end else begin
          anchor_neg_nxt = new_neg;
          prev_x_nxt     = rd_x;
          prev_y_nxt     = rd_y;
          run_empty_nxt  = 1'b1;
          if (new_neg != anchor_neg_r) begin
            dx_nxt    = pipt_pkg::DIFF_BITS'(rd_x) - pipt_pkg::DIFF_BITS'(prev_x_r);
            dy_nxt    = pipt_pkg::DIFF_BITS'(rd_y) - pipt_pkg::DIFF_BITS'(prev_y_r);
            ex_nxt    = pipt_pkg::FAR_BITS'(px_r) - pipt_pkg::FAR_BITS'(prev_x_r);
            gy_nxt    = pipt_pkg::DIFF_BITS'(py_r) - pipt_pkg::DIFF_BITS'(prev_y_r);
            fx_nxt    = far_r - pipt_pkg::FAR_BITS'(prev_x_r);
            last_nxt  = (k_r >= n_k);
            k_nxt     = kp1;
            ram_raddr = wrap_idx(kp1, n_k);
            state_nxt = S_MUL0;
          end else if (k_r >= n_k) begin
            fin     = 1'b1;
            fin_res = parity_r;
          end else begin
            k_nxt     = kp1;
            ram_raddr = wrap_idx(kp1, n_k);
          end
        end
      end
      S_MUL0: begin
        p_nxt     = mul_p;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        q_nxt     = mul_p;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        r_nxt     = mul_p;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (c1 == '0 || c2 == '0) begin
          fin     = 1'b1;
          fin_res = 1'b1;
        end else begin
          par_tmp    = parity_r ^ (c1[pipt_pkg::PROD_BITS] != c2[pipt_pkg::PROD_BITS]);
          parity_nxt = par_tmp;
          if (last_r) begin
            fin     = 1'b1;
            fin_res = par_tmp;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt                     = S_IDLE;
      out_valid_nxt                 = 1'b1;
      out_item_nxt.inside_res       = fin_res;
      out_item_nxt.vertices_dropped = overflow_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_path_r <= 1'b0;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      box_xl_r    <= '0;
      box_xh_r    <= '0;
      box_yl_r    <= '0;
      box_yh_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_path_r <= open_path_nxt;
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      box_xl_r    <= box_xl_nxt;
      box_xh_r    <= box_xh_nxt;
      box_yl_r    <= box_yl_nxt;
      box_yh_r    <= box_yh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    far_r        <= far_nxt;
    k_r          <= k_nxt;
    anchor_neg_r <= anchor_neg_nxt;
    run_empty_r  <= run_empty_nxt;
    run_x_r      <= run_x_nxt;
    prev_x_r     <= prev_x_nxt;
    prev_y_r     <= prev_y_nxt;
    parity_r     <= parity_nxt;
    last_r       <= last_nxt;
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    gy_r         <= gy_nxt;
    ex_r         <= ex_nxt;
    fx_r         <= fx_nxt;
    p_r          <= p_nxt;
    q_r          <= q_nxt;
    r_r          <= r_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // appends never give a result
  `PIPT_ASSERT(a_append_silent, (start && !busy && in_item.action == pipt_pkg::ACT_APPEND) |=> !out_valid, "append produced a result")
  // a taken query is either still running or answered
  `PIPT_ASSERT(a_query_progress, (start && !busy && in_item.action == pipt_pkg::ACT_QUERY) |=> (busy || out_valid), "query lost")
  // a result always coincides with the engine being free again
  `PIPT_ASSERT(a_result_idle, out_valid |-> !busy, "result while busy")
  // vertex count stays within capacity
  `PIPT_ASSERT(a_count_range, count_r <= MAX_CNT, "vertex count beyond capacity")

endmodule

`default_nettype wire

[tb/tb_point_in_polygon_test_top.sv]
// self-checking testbench of the polygon hit-test block: directed table, then random shapes
`timescale 1ns / 1ps

module tb_point_in_polygon_test_top;

  localparam int MAX_VERTICES = 64;
  localparam int ITEM_TARGET  = 1550;
  localparam int IDLE_LIMIT   = 3000;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TYPED,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t           kind;
    pipt_pkg::in_item_t  item;
    pipt_pkg::out_item_t want;
    logic                cfg_val;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  pipt_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  pipt_pkg::out_item_t out_item;
  logic                cfg_we = 1'b0;
  logic                cfg_wdata = 1'b0;

  // sideband that travels with each driven transaction
  logic                drv_typed = 1'b0;
  pipt_pkg::out_item_t drv_want = '0;

  // shadow of the block state
  pipt_pkg::coord_t    poly_x [MAX_VERTICES];
  pipt_pkg::coord_t    poly_y [MAX_VERTICES];
  int                  poly_count = 0;
  pipt_pkg::coord_t    box_x_lo = '0;
  pipt_pkg::coord_hi_t box_x_hi = '0;
  pipt_pkg::coord_t    box_y_lo = '0;
  pipt_pkg::coord_hi_t box_y_hi = '0;
  logic                dropped_seen = 1'b0;
  logic                open_path_bit = 1'b0;

  pipt_pkg::out_item_t pending_answers [$];
  int                  mismatches = 0;
  int                  items_sent = 0;
  int                  idle_cycles = 0;
  bit                  burst_mode = 1'b0;
  row_t                rows [$];

  point_in_polygon_test_top #(
    .MAX_VERTICES(MAX_VERTICES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  task automatic flag_mismatch(input string what, input logic got, input logic want);
    $display("mismatch at %0t: %s got %0b want %0b", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void store_vertex(input pipt_pkg::coord_t x, input pipt_pkg::coord_t y,
                                       input logic first);
    if (first) begin
      poly_count = 0;
      dropped_seen = 1'b0;
    end
    if (poly_count >= MAX_VERTICES) begin
      dropped_seen = 1'b1;
      return;
    end
    poly_x[poly_count] = x;
    poly_y[poly_count] = y;
    if (poly_count == 0) begin
      box_x_lo = x;
      box_x_hi = pipt_pkg::coord_hi_t'(longint'(x) + 1);
      box_y_lo = y;
      box_y_hi = pipt_pkg::coord_hi_t'(longint'(y) + 1);
    end else begin
      if (longint'(x) < longint'(box_x_lo)) box_x_lo = x;
      if (longint'(x) + 1 > longint'(box_x_hi))
        box_x_hi = pipt_pkg::coord_hi_t'(longint'(x) + 1);
      if (longint'(y) < longint'(box_y_lo)) box_y_lo = y;
      if (longint'(y) + 1 > longint'(box_y_hi))
        box_y_hi = pipt_pkg::coord_hi_t'(longint'(y) + 1);
    end
    poly_count++;
  endfunction

  function automatic logic inside_polygon(input pipt_pkg::coord_t qx, input pipt_pkg::coord_t qy);
    int unsigned n, i, run_start, crossings;
    longint px, py, far_x, d1, d2, a, b, x1, y1, x2, y2, c1, c2;
    n = poly_count;
    crossings = 0;
    px = longint'(qx);
    py = longint'(qy);
    if (open_path_bit || n == 0) return 1'b0;
    if (px < longint'(box_x_lo) || px >= longint'(box_x_hi) ||
        py < longint'(box_y_lo) || py >= longint'(box_y_hi)) return 1'b0;
    far_x = longint'(box_x_hi) + (longint'(box_x_hi) - longint'(box_x_lo));
    i = 0;
    while (i < n) begin
      d1 = longint'(poly_y[i]) - py;
      if (d1 != 0) begin
        run_start = i;
        d2 = longint'(poly_y[(i + 1) % n]) - py;
        // step over vertices lying on the ray line
        while (d2 == 0) begin
          i++;
          d2 = longint'(poly_y[(i + 1) % n]) - py;
        end
        if (run_start != i) begin
          a = longint'(poly_x[(run_start + 1) % n]) - px;
          b = longint'(poly_x[i % n]) - px;
          if (a * b <= 0) return 1'b1;
        end
        if ((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0)) begin
          x1 = longint'(poly_x[i % n]);
          y1 = longint'(poly_y[i % n]);
          x2 = longint'(poly_x[(i + 1) % n]);
          y2 = longint'(poly_y[(i + 1) % n]);
          c1 = (px - x1) * (y2 - y1) - (py - y1) * (x2 - x1);
          c2 = (far_x - x1) * (y2 - y1) - (py - y1) * (x2 - x1);
          if (c1 == 0 || c2 == 0) return 1'b1;
          if ((c1 < 0) != (c2 < 0)) crossings++;
        end
      end
      i++;
    end
    return crossings[0];
  endfunction

  // result check, shadow update and watchdog
  always @(posedge clk) begin
    pipt_pkg::out_item_t want;
    if (rst_n) begin
      idle_cycles = idle_cycles + 1;
      if (out_valid) begin
        idle_cycles = 0;
        if (pending_answers.size() == 0) begin
          flag_mismatch("result with no query waiting", out_valid, 1'b0);
        end else begin
          want = pending_answers.pop_front();
          if (out_item.inside_res !== want.inside_res)
            flag_mismatch("inside_res", out_item.inside_res, want.inside_res);
          if (out_item.vertices_dropped !== want.vertices_dropped)
            flag_mismatch("vertices_dropped", out_item.vertices_dropped, want.vertices_dropped);
        end
      end
      if (cfg_we) begin
        idle_cycles = 0;
        open_path_bit = cfg_wdata;
      end
      if (start && !busy) begin
        idle_cycles = 0;
        if (in_item.action == pipt_pkg::ACT_APPEND) begin
          store_vertex(in_item.x_coord, in_item.y_coord, in_item.first_vertex);
        end else begin
          want.inside_res = inside_polygon(in_item.x_coord, in_item.y_coord);
          want.vertices_dropped = dropped_seen;
          pending_answers.push_back(drv_typed ? drv_want : want);
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout at %0t", $realtime);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input pipt_pkg::in_item_t it, input logic typed,
                           input pipt_pkg::out_item_t want);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_item   <= it;
    drv_typed <= typed;
    drv_want  <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_open_path(input logic v);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic row_t mk_row(input row_kind_t kind, input pipt_pkg::action_t act,
                                  input int x, input int y, input logic first,
                                  input logic want_in, input logic want_drop);
    row_t r;
    r.kind = kind;
    r.item.action = act;
    r.item.x_coord = pipt_pkg::coord_t'(x);
    r.item.y_coord = pipt_pkg::coord_t'(y);
    r.item.first_vertex = first;
    r.want.inside_res = want_in;
    r.want.vertices_dropped = want_drop;
    r.cfg_val = first;
    return r;
  endfunction

  function automatic pipt_pkg::coord_t rand_coord(input int mode);
    case (mode)
      0, 1, 2, 3: return pipt_pkg::coord_t'(int'($urandom_range(0, 40)) - 20);
      4: return pipt_pkg::coord_t'($urandom);
      default: begin
        case ($urandom_range(0, 6))
          0: return pipt_pkg::coord_t'(-32768);
          1: return pipt_pkg::coord_t'(-32767);
          2: return pipt_pkg::coord_t'(-1);
          3: return pipt_pkg::coord_t'(0);
          4: return pipt_pkg::coord_t'(1);
          5: return pipt_pkg::coord_t'(32766);
          default: return pipt_pkg::coord_t'(32767);
        endcase
      end
    endcase
  endfunction

  function automatic pipt_pkg::in_item_t pick_query();
    pipt_pkg::in_item_t it;
    longint w, h;
    int r, k;
    it.action = pipt_pkg::ACT_QUERY;
    it.first_vertex = logic'($urandom_range(0, 1));
    w = longint'(box_x_hi) - longint'(box_x_lo);
    h = longint'(box_y_hi) - longint'(box_y_lo);
    r = $urandom_range(0, 9);
    if (poly_count == 0 || r == 9) begin
      it.x_coord = pipt_pkg::coord_t'($urandom);
      it.y_coord = pipt_pkg::coord_t'($urandom);
    end else if (r < 7) begin
      it.x_coord = pipt_pkg::coord_t'(longint'(box_x_lo) - 1 +
                                      longint'($urandom_range(0, w + 1)));
      it.y_coord = pipt_pkg::coord_t'(longint'(box_y_lo) - 1 +
                                      longint'($urandom_range(0, h + 1)));
    end else begin
      // on the line of a stored vertex
      k = $urandom_range(0, poly_count - 1);
      it.y_coord = poly_y[k];
      it.x_coord = (r == 7) ? poly_x[$urandom_range(0, poly_count - 1)] :
                   pipt_pkg::coord_t'(longint'(box_x_lo) + longint'($urandom_range(0, w - 1)));
    end
    return it;
  endfunction

  initial begin
    pipt_pkg::in_item_t  it;
    pipt_pkg::out_item_t none;
    int size, mode, nq, shape;
    none = '0;
    rows.push_back(mk_row(ROW_TYPED,   pipt_pkg::ACT_QUERY,  0,  0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_APPEND, 0,  0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_APPEND, 10, 0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_APPEND, 10, 10, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_APPEND, 0,  10, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_QUERY,  5,  5, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_QUERY,  0,  5, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_TYPED,   pipt_pkg::ACT_QUERY,  11, 5, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_TYPED,   pipt_pkg::ACT_QUERY,  5, -1, 1'b1, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_QUERY,  5,  0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_QUERY,  10, 10, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_CFG,     pipt_pkg::ACT_QUERY,  0,  0, 1'b1, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_TYPED,   pipt_pkg::ACT_QUERY,  5,  5, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_CFG,     pipt_pkg::ACT_QUERY,  0,  0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_APPEND, -32768, -32768, 1'b1, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_APPEND, 32767, -32768, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_APPEND, 32767, 32767, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_APPEND, -32768, 32767, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_QUERY,  0,  0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_QUERY,  -32768, 32767, 1'b1, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_PREDICT, pipt_pkg::ACT_QUERY,  32767, 0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(ROW_TYPED,   pipt_pkg::ACT_QUERY,  -32768, -32769, 1'b0, 1'b1, 1'b0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG) write_open_path(rows[r].cfg_val);
      else send_item(rows[r].item, rows[r].kind == ROW_TYPED, rows[r].want);
    end

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) write_open_path($urandom_range(0, 2) == 0);
      burst_mode = ($urandom_range(0, 3) == 0);
      shape = $urandom_range(0, 9);
      if (shape < 6) size = $urandom_range(3, 8);
      else if (shape == 6) size = $urandom_range(1, 2);
      else if (shape < 9) size = $urandom_range(9, 20);
      else size = $urandom_range(60, 70);
      mode = $urandom_range(0, 5);
      for (int k = 0; k < size; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray transaction in the middle of a shape
          it.action = pipt_pkg::action_t'($urandom_range(0, 1));
          it.x_coord = pipt_pkg::coord_t'($urandom);
          it.y_coord = pipt_pkg::coord_t'($urandom);
          it.first_vertex = 1'b0;
          send_item(it, 1'b0, none);
        end
        it.action = pipt_pkg::ACT_APPEND;
        it.x_coord = rand_coord(mode);
        it.y_coord = rand_coord(mode);
        it.first_vertex = (k == 0) && ($urandom_range(0, 7) != 0);
        send_item(it, 1'b0, none);
      end
      nq = $urandom_range(4, 12);
      for (int q = 0; q < nq; q++) send_item(pick_query(), 1'b0, none);
      if ($urandom_range(0, 7) == 0) drain_block();
    end

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4 * MAX_VERTICES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
